@@ hdl/ihex_pkg.sv @@
// Shared constants, types and the hex digit decoder for the Intel HEX parser.
`timescale 1ns / 1ps
`default_nettype none

package ihex_pkg;

  localparam int unsigned AddrBits   = 16;
  localparam int unsigned ColBits    = 10;
  localparam int unsigned CountBits  = 8;
  localparam int unsigned NibBits    = 4;
  localparam int unsigned LenBits    = AddrBits + 1;
  localparam int unsigned CharBits   = 8;
  localparam int unsigned OutBits    = AddrBits + CountBits + LenBits;
  localparam int unsigned OutPadBits = ((OutBits + 7) / 8) * 8;

  localparam logic [CharBits-1:0] LineFeed = 8'h0A;
  localparam logic [ColBits-1:0]  ColMax   = {ColBits{1'b1}};

  // column codes inside one record line
  localparam logic [ColBits-1:0] ColCountHi = 10'd1;
  localparam logic [ColBits-1:0] ColCountLo = 10'd2;
  localparam logic [ColBits-1:0] ColAddr0   = 10'd3;
  localparam logic [ColBits-1:0] ColAddr1   = 10'd4;
  localparam logic [ColBits-1:0] ColAddr3   = 10'd6;
  localparam logic [ColBits-1:0] ColData    = 10'd9;
  localparam logic [ColBits-1:0] ColByte0   = 10'd10;

  typedef struct packed {
    logic [LenBits-1:0]   image_length;
    logic [CountBits-1:0] byte_value;
    logic [AddrBits-1:0]  byte_address;
  } out_beat_t;

  // ASCII hex digit to nibble; anything else reads as zero
  function automatic logic [NibBits-1:0] hex_nibble(input logic [CharBits-1:0] c);
    logic [NibBits-1:0] n;
    n = '0;
    if (c >= 8'h30 && c <= 8'h39) n = c[NibBits-1:0];
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      n = c[NibBits-1:0] + 4'd9;
    return n;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ihex_out_stage.sv @@
// Output register stage: holds one result beat and lets the input side run on.
`timescale 1ns / 1ps
`default_nettype none

module ihex_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              beat_valid_i,
  input  ihex_pkg::out_beat_t    beat_i,
  output logic                   beat_ready_o,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [ihex_pkg::OutPadBits-1:0] m_axis_tdata_o
);
  import ihex_pkg::*;

  logic      valid_q, valid_d;
  out_beat_t beat_q;

  assign beat_ready_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (beat_ready_o) valid_d = beat_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_ready_o && beat_valid_i) beat_q <= beat_i;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {{(OutPadBits - OutBits){1'b0}}, beat_q};

endmodule

`default_nettype wire

@@ hdl/intel_hex_record_to_binary.sv @@
// Top level: Intel HEX character stream in, binary image byte writes out.
//
// Usage
//   s_axis: one ASCII character of the hex file per beat (tdata[7:0]).
//   m_axis: one write per decoded data byte of a selected record;
//           tdata[15:0] byte_address, [23:16] byte_value,
//           [40:24] image_length, [47:41] zero.
//   cfg: cfg_we_i writes the image base from cfg_wdata_i; change it only
//        while the stream is idle.
//   Records whose address is below the image base are skipped; kept records
//   land at address - base. image_length is the running maximum of
//   (address - base + byte count) over kept records.
//   A data byte appears on m_axis in the cycle after the beat with its
//   second digit is taken. Throughput: one character per cycle while
//   m_axis is not stalled, set by the single output register in ihex_out_stage.
//   Stall: when m_axis holds a beat that is not taken, s_axis_tready
//   drops; characters that produce no write still pass only as the
//   register frees, so nothing is lost or repeated.
//   Reset: column, record state, image length and the image base clear to
//   zero; the output register is emptied.
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_record_to_binary (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write
  input  wire logic        cfg_we_i,
  input  wire logic [ihex_pkg::AddrBits-1:0] cfg_wdata_i,   // image base
  // character stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [ihex_pkg::CharBits-1:0] s_axis_tdata,  // [7:0] char_in
  // byte writes out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] byte_address, [23:16] byte_value, [40:24] image_length
  output logic [ihex_pkg::OutPadBits-1:0] m_axis_tdata
);
  import ihex_pkg::*;

  logic [AddrBits-1:0]  offset_q;
  logic [ColBits-1:0]   col_q, col_d;
  logic [CountBits-1:0] count_q, count_d;
  logic [AddrBits-1:0]  addr_q, addr_d;
  logic [NibBits-1:0]   hi_nib_q, hi_nib_d;
  logic                 sel_q, sel_d;
  logic [LenBits-1:0]   len_q, len_d;

  logic                 in_acc;
  logic                 is_lf;
  logic [NibBits-1:0]   nib;
  logic [AddrBits-1:0]  addr_shift;
  logic [LenBits-1:0]   rec_end;
  logic [ColBits-1:0]   col_rel;
  logic [ColBits-2:0]   idx;
  logic                 emit;
  out_beat_t            beat;
  logic                 beat_ready;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = beat_ready;
  assign is_lf      = (s_axis_tdata == LineFeed);
  assign nib        = hex_nibble(s_axis_tdata);
  assign addr_shift = {addr_q[AddrBits-NibBits-1:0], nib};
  // end of record in image space, taken at the last address digit
  assign rec_end    = {1'b0, addr_shift - offset_q} + {{(LenBits-CountBits){1'b0}}, count_q};
  assign col_rel    = col_q - ColByte0;
  assign idx        = col_rel[ColBits-1:1];

  always_comb begin
    col_d    = col_q;
    count_d  = count_q;
    addr_d   = addr_q;
    hi_nib_d = hi_nib_q;
    sel_d    = sel_q;
    len_d    = len_q;
    emit     = 1'b0;
    if (is_lf) begin
      col_d = '0;
      sel_d = 1'b0;
    end else begin
      if (col_q != ColMax) col_d = col_q + ColBits'(1);
      if (col_q == ColCountHi) begin
        count_d = {{(CountBits-NibBits){1'b0}}, nib};
      end else if (col_q == ColCountLo) begin
        count_d = {count_q[CountBits-NibBits-1:0], nib};
      end else if (col_q == ColAddr0) begin
        addr_d = {{(AddrBits-NibBits){1'b0}}, nib};
      end else if (col_q >= ColAddr1 && col_q <= ColAddr3) begin
        addr_d = addr_shift;
        if (col_q == ColAddr3) begin
          sel_d = (addr_shift >= offset_q);
          if (addr_shift >= offset_q && rec_end > len_q) len_d = rec_end;
        end
      end else if (col_q >= ColData) begin
        if (col_q[0]) hi_nib_d = nib;
        else emit = sel_q && ({1'b0, idx} < {{(ColBits-CountBits){1'b0}}, count_q});
      end
    end
  end

  assign beat.byte_address = addr_q - offset_q + {{(AddrBits-ColBits+1){1'b0}}, idx};
  assign beat.byte_value   = {hi_nib_q, nib};
  assign beat.image_length = len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      col_q    <= '0;
      count_q  <= '0;
      addr_q   <= '0;
      hi_nib_q <= '0;
      sel_q    <= 1'b0;
      len_q    <= '0;
    end else begin
      if (cfg_we_i) offset_q <= cfg_wdata_i;
      if (in_acc) begin
        col_q    <= col_d;
        count_q  <= count_d;
        addr_q   <= addr_d;
        hi_nib_q <= hi_nib_d;
        sel_q    <= sel_d;
        len_q    <= len_d;
      end
    end
  end

  ihex_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .beat_valid_i    (in_acc && emit),
    .beat_i          (beat),
    .beat_ready_o    (beat_ready),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  // line feed restarts the column count and drops the record
  a_lf_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_lf |=> col_q == '0 && !sel_q)
    else $error("line feed did not restart the line");

  // a decoded byte always shows up on the output next cycle
  a_emit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && emit |=> m_axis_tvalid)
    else $error("decoded byte missing from output");

  // image length only grows
  a_len_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> len_q >= $past(len_q))
    else $error("image length shrank");

  // writes only come from selected records
  a_emit_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> sel_q && !col_q[0])
    else $error("write from unselected record or odd column");

endmodule

`default_nettype wire

@@ verif/ihex_tb_pkg.sv @@
// Scoreboard class for the Intel HEX parser bench: predicts and checks the byte writes.
`timescale 1ns / 1ps

package ihex_tb_pkg;

  import ihex_pkg::*;

  class ihex_image_scoreboard;

    logic [AddrBits-1:0]  image_base;
    logic [ColBits-1:0]   column;
    logic [CountBits-1:0] byte_count;
    logic [AddrBits-1:0]  record_address;
    logic [NibBits-1:0]   high_nibble;
    bit                   record_selected;
    logic [LenBits-1:0]   length_so_far;
    out_beat_t            expected_writes[$];
    int unsigned          failures;

    function new();
      image_base      = '0;
      column          = '0;
      byte_count      = '0;
      record_address  = '0;
      high_nibble     = '0;
      record_selected = 1'b0;
      length_so_far   = '0;
      failures        = 0;
    endfunction

    function void set_offset(logic [AddrBits-1:0] value);
      image_base = value;
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction

    // non-hex reads as zero
    function logic [NibBits-1:0] digit_value(logic [CharBits-1:0] c);
      logic [CharBits-1:0] v;
      v = 8'h00;
      if (c inside {[8'h30:8'h39]}) v = c - 8'h30;
      else if (c inside {[8'h41:8'h46]}) v = c - 8'h37;
      else if (c inside {[8'h61:8'h66]}) v = c - 8'h57;
      return v[NibBits-1:0];
    endfunction

    // one accepted character beat
    function void note_char(logic [CharBits-1:0] c);
      logic [ColBits-1:0] col;
      logic [ColBits-1:0] idx;
      logic [NibBits-1:0] nib;
      logic [LenBits-1:0] span;
      out_beat_t          wr;
      col = column;
      if (c == LineFeed) begin
        column          = '0;
        record_selected = 1'b0;
        return;
      end
      nib = digit_value(c);
      if (col == ColCountHi) begin
        byte_count = {4'h0, nib};
      end else if (col == ColCountLo) begin
        byte_count = {byte_count[NibBits-1:0], nib};
      end else if (col == ColAddr0) begin
        record_address = {12'h000, nib};
      end else if (col >= ColAddr1 && col <= ColAddr3) begin
        record_address = {record_address[AddrBits-NibBits-1:0], nib};
        if (col == ColAddr3) begin
          record_selected = record_address >= image_base;
          if (record_selected) begin
            span = {1'b0, record_address} - {1'b0, image_base} + {9'h000, byte_count};
            if (span > length_so_far) length_so_far = span;
          end
        end
      end else if (col >= ColData) begin
        if (col[0]) begin
          high_nibble = nib;
        end else begin
          idx = (col - ColByte0) >> 1;
          if (record_selected && idx < {2'b00, byte_count}) begin
            wr.byte_address = record_address - image_base + {6'h00, idx};
            wr.byte_value   = {high_nibble, nib};
            wr.image_length = length_so_far;
            expected_writes.push_back(wr);
          end
        end
      end
      if (column != ColMax) column = column + 1'b1;
    endfunction

    // one accepted write beat
    function void check_beat(logic [OutPadBits-1:0] beat);
      out_beat_t got;
      out_beat_t want;
      got = beat[OutBits-1:0];
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected write: expected none, actual addr %h value %h length %h",
                 $time, got.byte_address, got.byte_value, got.image_length);
        failures++;
        return;
      end
      want = expected_writes.pop_front();
      if (got.byte_address !== want.byte_address) begin
        $display("%0t: byte_address mismatch: expected %h actual %h",
                 $time, want.byte_address, got.byte_address);
        failures++;
      end
      if (got.byte_value !== want.byte_value) begin
        $display("%0t: byte_value mismatch: expected %h actual %h",
                 $time, want.byte_value, got.byte_value);
        failures++;
      end
      if (got.image_length !== want.image_length) begin
        $display("%0t: image_length mismatch: expected %h actual %h",
                 $time, want.image_length, got.image_length);
        failures++;
      end
      if (beat[OutPadBits-1:OutBits] !== '0) begin
        $display("%0t: tdata pad mismatch: expected %h actual %h",
                 $time, {(OutPadBits-OutBits){1'b0}}, beat[OutPadBits-1:OutBits]);
        failures++;
      end
    endfunction

  endclass

endpackage

@@ verif/tb_top.sv @@
// Bench top: drives hex text into intel_hex_record_to_binary and scores the byte writes.
`timescale 1ns / 1ps

module tb_top;

  import ihex_pkg::*;
  import ihex_tb_pkg::*;

  // clock, reset and every DUT input start at known values
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [AddrBits-1:0]   cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [CharBits-1:0]   s_axis_tdata  = '0;   // [7:0] char_in
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [15:0] byte_address, [23:16] byte_value, [40:24] image_length, [47:41] pad
  logic [OutPadBits-1:0] m_axis_tdata;

  ihex_image_scoreboard sb;

  // calm: no idling on either side (last phase)
  bit          calm          = 1'b0;
  // bumped by the sender to ask the receiver for one long hold-off
  int unsigned hold_requests = 0;

  // text of the record being built, sent beat by beat
  logic [CharBits-1:0] text_q[$];

  intel_hex_record_to_binary u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // hard stop; far beyond the slowest legal run (~0.5 ms)
  initial begin
    #4_000_000;
    $display("** intel_hex_record_to_binary: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Helpers that build record text
  // ---------------------------------------------------------------------------

  // hex digit, letter case picked at random
  function automatic logic [CharBits-1:0] hex_char(logic [NibBits-1:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic void push_hex(logic [7:0] b);
    text_q.push_back(hex_char(b[7:4]));
    text_q.push_back(hex_char(b[3:0]));
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Every task below is entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // one character beat; optional idle burst first, then hold until taken
  task automatic send_char(input logic [CharBits-1:0] c);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_char(c);
    @(negedge clk_i);
  endtask

  task automatic send_queued();
    foreach (text_q[i]) send_char(text_q[i]);
    text_q.delete();
  endtask

  // stop offering, wait for every pending write, then let the pipe drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // single-cycle config strobe; only called with the stream idle
  task automatic write_offset(input logic [AddrBits-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_offset(value);
  endtask

  // One record line. Mostly well formed with random content; the rest is
  // cut short, padded with extra digits, or has random bytes dropped in.
  task automatic send_record(input logic [AddrBits-1:0] offset_now, inout int items);
    int                  count;
    int                  r;
    int                  mode;
    int                  cut;
    logic [AddrBits-1:0] addr;
    r = $urandom_range(0, 99);
    if (r < 75)      count = $urandom_range(0, 16);
    else if (r < 98) count = $urandom_range(17, 32);
    else             count = $urandom_range(33, 255);
    // bias addresses to land at or above the offset so most records map
    if ($urandom_range(0, 9) < 6)
      addr = offset_now + AddrBits'($urandom_range(0, 32'hFFFF - offset_now));
    else
      addr = AddrBits'($urandom);
    text_q.push_back(8'h3A);
    push_hex(count[7:0]);
    push_hex(addr[15:8]);
    push_hex(addr[7:0]);
    push_hex(8'($urandom_range(0, 255)));         // record type, not decoded
    repeat (count) push_hex(8'($urandom_range(0, 255)));
    push_hex(8'($urandom_range(0, 255)));         // checksum, not decoded
    mode = $urandom_range(0, 99);
    if (mode >= 80 && mode < 88) begin
      // short line: line feed lands anywhere after the colon
      cut = $urandom_range(1, text_q.size() - 1);
      while (text_q.size() > cut) void'(text_q.pop_back());
    end else if (mode >= 88 && mode < 94) begin
      repeat ($urandom_range(1, 6)) push_hex(8'($urandom_range(0, 255)));
    end else if (mode >= 94) begin
      // noise: any byte, line feed included, at random spots
      repeat ($urandom_range(1, 3))
        text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 1)) text_q.push_back(8'h0D);
    text_q.push_back(LineFeed);
    items += text_q.size();
    send_queued();
  endtask

  // Line long enough to pin the column counter at its top; random bytes
  // with no line feed, so nothing past the data columns may emit.
  task automatic send_long_line();
    logic [CharBits-1:0] c;
    push_str(":FF");
    push_hex(8'($urandom_range(0, 255)));
    push_hex(8'($urandom_range(0, 255)));
    repeat (1100) begin
      c = 8'($urandom_range(0, 255));
      text_q.push_back(c == LineFeed ? 8'hFF : c);
    end
    text_q.push_back(LineFeed);
    send_queued();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int                  sent;
    logic [AddrBits-1:0] phase_offset;
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_offset(16'h0000);

    // Directed: top address with wrap of the next byte address, mixed case,
    // non-hex digit, image length past 16 bits.
    push_str(":02FFFF00aF9G");
    text_q.push_back(LineFeed);
    // line ending before the address is complete; extreme char codes
    push_str(":1");
    text_q.push_back(8'hFF);
    text_q.push_back(8'h00);
    text_q.push_back(LineFeed);
    // offset change after the address columns: selection keeps the old
    // offset, byte addresses take the new one; trailing excess non-hex
    push_str(":04123400");
    send_queued();
    settle();
    write_offset(16'h1000);
    push_str("A1B2C3D4xx");
    text_q.push_back(LineFeed);
    send_queued();

    // Random phases, each under its own offset; the stream is idle at every
    // boundary (sender waits out all pending writes before the write).
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0:       phase_offset = 16'h0000;
        1:       phase_offset = 16'hFFFF;
        3:       phase_offset = 16'h8000;
        default: phase_offset = AddrBits'($urandom);
      endcase
      write_offset(phase_offset);
      if (p == 0) hold_requests++;     // receiver stalls long, input backs up
      if (p == 2) send_long_line();
      if (p == 5) calm = 1'b1;
      sent = 0;
      while (sent < 95) send_record(phase_offset, sent);
    end

    settle();
    repeat (10) @(negedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("** intel_hex_record_to_binary: PASSED **");
    end else begin
      if (sb.pending() != 0)
        $display("%0t: %0d expected writes never arrived", $time, sb.pending());
      $display("** intel_hex_record_to_binary: FAILED **");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random tready bursts, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int          hold;
    int unsigned served;
    hold   = 0;
    served = 0;
    forever begin
      @(negedge clk_i);
      if (served != hold_requests) begin
        served = hold_requests;
        hold   = 400;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 19) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // write beats are scored at the edge that takes them
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
  end

endmodule
